[hdl/psa_pkg.sv]
// shared types, constants and lookup tables of the particle splat accumulator
package psa_pkg;

    // default geometry
    localparam int PSA_IMG_WIDTH  = 256;
    localparam int PSA_IMG_HEIGHT = 256;
    localparam int PSA_DOT_SPAN   = 4;

    // item actions
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_BODY  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_SPEED_FLOOR = 2'd0;
    localparam logic [1:0] REG_SPEED_SPAN  = 2'd1;
    localparam logic [1:0] REG_SHARPNESS   = 2'd2;
    localparam logic [1:0] REG_BRIGHTNESS  = 2'd3;

    // register reset values
    localparam logic [31:0] SPEED_FLOOR_RST = 32'd0;
    localparam logic [31:0] SPEED_SPAN_RST  = 32'd35000;
    localparam logic [15:0] SHARPNESS_RST   = 16'd4096;
    localparam logic [15:0] BRIGHTNESS_RST  = 16'd4096;

    // fixed point
    localparam int ACC_W = 20;
    localparam logic [ACC_W-1:0] ACC_MAX = 20'hFFFFF;
    localparam logic signed [19:0] C_ONE   = 20'sd65536;
    localparam logic signed [19:0] C_HALF  = 20'sd32768;
    localparam logic signed [19:0] C_THIRD = 20'sd21823;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [22:0] EXP_CAP   = 23'd4194304;
    localparam logic [22:0] SOFT_LIM  = 23'd524288;
    localparam logic [7:0]  K_LIMIT   = 8'd40;

    // projection product width and exponent argument width
    localparam int CXW = 40;
    localparam int XAW = 23;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_PROJ, S_EDGE, S_SQ, S_SQRT, S_SPD, S_DIV,
        S_PINIT, S_PSQRT, S_COLOR, S_E1, S_E2, S_E3, S_W1, S_W2,
        S_W3, S_W4, S_WDIV, S_WGET, S_MUL, S_WR, S_RD1, S_RD2
    } t_state;

    // 2^(k/16), Q.16
    function automatic logic [17:0] pow2_tab(input logic [4:0] idx);
        logic [17:0] v;
        unique case (idx)
            5'd0:  v = 18'd65536;
            5'd1:  v = 18'd68438;
            5'd2:  v = 18'd71468;
            5'd3:  v = 18'd74632;
            5'd4:  v = 18'd77936;
            5'd5:  v = 18'd81386;
            5'd6:  v = 18'd84990;
            5'd7:  v = 18'd88752;
            5'd8:  v = 18'd92682;
            5'd9:  v = 18'd96785;
            5'd10: v = 18'd101070;
            5'd11: v = 18'd105545;
            5'd12: v = 18'd110218;
            5'd13: v = 18'd115098;
            5'd14: v = 18'd120194;
            5'd15: v = 18'd125515;
            5'd16: v = 18'd131072;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    // log2(1 + 2^-d) at steps of one half, Q.16
    function automatic logic [16:0] soft_tab(input logic [4:0] idx);
        logic [16:0] v;
        unique case (idx)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd50564;
            5'd2:  v = 17'd38336;
            5'd3:  v = 17'd28623;
            5'd4:  v = 17'd21098;
            5'd5:  v = 17'd15391;
            5'd6:  v = 17'd11137;
            5'd7:  v = 17'd8009;
            5'd8:  v = 17'd5732;
            5'd9:  v = 17'd4089;
            5'd10: v = 17'd2909;
            5'd11: v = 17'd2067;
            5'd12: v = 17'd1466;
            5'd13: v = 17'd1039;
            5'd14: v = 17'd736;
            5'd15: v = 17'd521;
            5'd16: v = 17'd369;
            default: v = 17'd369;
        endcase
        return v;
    endfunction

endpackage

[hdl/psa_if.sv]
// channel interfaces: body/command items in, pixel bytes out
interface psa_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [15:0]        pixel_index;

    modport source (output valid, action, pos_x, pos_y, vel_x, vel_y, vel_z, pixel_index,
                    input ready);
    modport sink (input valid, action, pos_x, pos_y, vel_x, vel_y, vel_z, pixel_index,
                  output ready);
endinterface

interface psa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

[hdl/psa_ram.sv]
// generic simple dual port ram with registered read
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/particle_splat_accumulator.sv]
// particle splat accumulator top level
// Splats particles into an RGB accumulation image held in one ram of
// IMG_WIDTH*IMG_HEIGHT words (three 20-bit Q4.16 channels per pixel). One item
// is worked at a time; the input is ready only while the block is idle. After
// reset and after every clear item the block sweeps the ram, one pixel per
// cycle, before it takes the next item. A read item reads one ram word and
// registers its bytes for the result transfer. A body item is dropped at the
// frame edge or as too slow; a drawn body works out its speed and colour,
// then the falloff arguments, then each pixel of the DOT_SPAN x DOT_SPAN dot
// in turn. Each pixel's weight comes from a radix-2 divider (36 steps),
// unless the pixel is far off, followed by a read-modify-write of the image
// ram. Configuration must be written over the APB port only while idle; the
// block itself does not enforce this. Reads return the register values.
module particle_splat_accumulator
    import psa_pkg::*;
#(
    parameter int IMG_WIDTH  = PSA_IMG_WIDTH,
    parameter int IMG_HEIGHT = PSA_IMG_HEIGHT,
    parameter int DOT_SPAN   = PSA_DOT_SPAN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psa_in_if.sink      i_body,
    psa_out_if.source   o_pixel,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NPIX = IMG_WIDTH * IMG_HEIGHT;
    localparam int AW   = $clog2(NPIX);
    localparam int H    = DOT_SPAN / 2;
    localparam int NOFF = 2 * H;
    localparam int DW   = $clog2(NOFF);
    localparam int OIW  = $clog2(2 * NOFF);
    localparam int XPW  = CXW - 23;
    localparam logic signed [CXW-1:0] CX_W = CXW'(IMG_WIDTH);
    localparam logic signed [CXW-1:0] CX_H = CXW'(IMG_HEIGHT);
    localparam logic signed [XPW-1:0] X_LO = XPW'(DOT_SPAN);
    localparam logic signed [XPW-1:0] X_HI = XPW'(IMG_WIDTH - DOT_SPAN);
    localparam logic signed [XPW-1:0] Y_HI = XPW'(IMG_HEIGHT - DOT_SPAN);

    t_state r_state, n_state;

    // configuration registers
    logic [31:0] r_floor, r_span;
    logic [15:0] r_sharp, r_bright;

    // captured item
    logic [15:0]        r_pix_idx;
    logic signed [23:0] r_pos_x, r_pos_y;
    logic signed [31:0] r_vel [3];

    // projection
    logic signed [CXW-1:0] r_cx, r_cy;
    logic signed [XPW-1:0] w_xp, w_yp;
    logic signed [24:0]    w_px1, w_py1;
    logic                  w_on_frame;

    // shared square root and divider
    logic [63:0] r_sq_n, r_sq_r, r_sq_bit, w_sq_t, w_sq;
    logic [31:0] w_av;
    logic [64:0] r_dv_rem, w_dv_sh;
    logic [63:0] r_dv_q, r_dv_den;
    logic        w_dv_ge;
    logic [5:0]  r_cnt;

    // speed and colour
    logic [31:0]        w_spd, w_diff;
    logic               r_full;
    logic [16:0]        w_port;
    logic signed [19:0] w_p, w_cg_a, w_cg_b;
    logic [16:0]        r_col [3];

    // falloff arguments
    logic [OIW-1:0] r_oi, w_rel_full;
    logic [DW-1:0]  w_rel;
    logic           w_is_y;
    logic [22:0]    w_f;
    logic [27:0]    w_d;
    logic [26:0]    w_mag;
    logic [23:0]    r_ea;
    logic [31:0]    r_et;
    logic [32:0]    w_ex;
    logic [XAW-1:0] r_xa [NOFF];
    logic [XAW-1:0] r_yb [NOFF];

    // weight
    logic [DW-1:0]  r_ii, r_jj;
    logic [XAW-1:0] w_xa, w_yb, r_hi, r_dd;
    logic [16:0]    w_s0, w_s1, w_soft;
    logic [23:0]    r_l2, w_lq;
    logic [17:0]    w_p0, w_p1, r_m;
    logic [7:0]     r_k;
    logic [20:0]    r_w;

    // accumulation
    logic [21:0]       r_add [3];
    logic [AW-1:0]     w_col, w_row, w_pix_addr, r_clr;
    logic [3*ACC_W-1:0] w_rdata, w_new, w_wdata;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic              w_we, w_re;

    // read result
    logic       r_rd_ok, r_out_valid, w_out_load;
    logic [7:0] r_red, r_green, r_blue;
    logic [7:0] w_byte [3];

    logic w_cfg_wr;

    // clamp a signed colour term to 0..1.0
    function automatic logic [16:0] f_clamp(input logic signed [19:0] v);
        logic [16:0] c;
        priority if (v < 20'sd0) begin
            c = 17'd0;
        end else if (v > C_ONE) begin
            c = ONE_Q16;
        end else begin
            c = v[16:0];
        end
        return c;
    endfunction

    psa_ram #(
        .WIDTH (3 * ACC_W),
        .DEPTH (NPIX)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // projection to pixel space, floor by arithmetic shift
    assign w_px1 = 25'(r_pos_x) + 25'sd4194304;
    assign w_py1 = 25'(r_pos_y) + 25'sd4194304;
    assign w_xp  = r_cx[CXW-1:23];
    assign w_yp  = r_cy[CXW-1:23];
    assign w_on_frame = (w_xp > X_LO) && (w_xp < X_HI) && (w_yp > X_LO) && (w_yp < Y_HI);

    // square of the selected velocity component
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    w_av = r_vel[0][31] ? 32'(-r_vel[0]) : r_vel[0];
            2'd1:    w_av = r_vel[1][31] ? 32'(-r_vel[1]) : r_vel[1];
            default: w_av = r_vel[2][31] ? 32'(-r_vel[2]) : r_vel[2];
        endcase
        w_sq = 64'(w_av) * 64'(w_av);
    end

    // one bit of the root, one bit of the quotient per cycle
    assign w_sq_t  = r_sq_r + r_sq_bit;
    assign w_dv_sh = {r_dv_rem[63:0], r_dv_q[63]};
    assign w_dv_ge = w_dv_sh >= {1'b0, r_dv_den};

    assign w_spd  = r_sq_r[31:0];
    assign w_diff = w_spd - r_floor;

    // colour ramp
    assign w_port = r_full ? ONE_Q16 : r_sq_r[16:0];
    assign w_p    = 20'(w_port);
    assign w_cg_a = w_p <<< 2;
    assign w_cg_b = (C_ONE - w_p) <<< 2;

    // sub-pixel offset of the current falloff argument
    assign w_is_y     = r_oi >= OIW'(NOFF);
    assign w_rel_full = w_is_y ? r_oi - OIW'(NOFF) : r_oi;
    assign w_rel      = w_rel_full[DW-1:0];
    assign w_f        = w_is_y ? r_cy[22:0] : r_cx[22:0];
    assign w_d        = ((28'(w_rel) - 28'(H)) << 23) - 28'(w_f);
    assign w_mag      = w_d[27] ? 27'(-w_d) : w_d[26:0];
    assign w_ex       = 33'((49'(r_et) * 49'(LOG2E_Q16)) >> 16);

    // weight datapath pieces
    assign w_xa = r_xa[r_ii];
    assign w_yb = r_yb[r_jj];
    assign w_s0 = soft_tab({1'b0, r_dd[18:15]});
    assign w_s1 = soft_tab(5'(r_dd[18:15]) + 5'd1);
    assign w_soft = (r_dd >= SOFT_LIM) ? 17'd0 :
                    w_s0 - 17'((32'(w_s0 - w_s1) * 32'(r_dd[14:0])) >> 15);
    assign w_lq = 24'((26'(r_l2) * 26'd3) >> 2);
    assign w_p0 = pow2_tab({1'b0, w_lq[15:12]});
    assign w_p1 = pow2_tab(5'(w_lq[15:12]) + 5'd1);

    // pixel of the current dot position
    assign w_col      = AW'(w_xp) + AW'(r_ii) - AW'(H);
    assign w_row      = AW'(w_yp) + AW'(r_jj) - AW'(H);
    assign w_pix_addr = w_col + w_row * AW'(IMG_WIDTH);

    // saturating add of the weighted colour, and byte conversion of a read
    always_comb begin
        logic [22:0] sum;
        logic [19:0] acc;
        logic [16:0] lim;
        for (int c = 0; c < 3; c++) begin
            acc = w_rdata[(2-c)*ACC_W +: ACC_W];
            sum = 23'(acc) + 23'(r_add[c]);
            w_new[(2-c)*ACC_W +: ACC_W] = (sum > 23'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
            lim = (acc > 20'(ONE_Q16)) ? ONE_Q16 : acc[16:0];
            w_byte[c] = r_rd_ok ? 8'((25'(lim) * 25'd255) >> 16) : 8'd0;
        end
    end

    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_out_load = (r_state == S_RD2) && (!r_out_valid || o_pixel.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(NPIX - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_body.valid) begin
                    unique case (i_body.action)
                        ACT_CLEAR: n_state = S_CLEAR;
                        ACT_BODY:  n_state = S_PROJ;
                        ACT_READ:  n_state = S_RD1;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_PROJ:  n_state = S_EDGE;
            S_EDGE:  n_state = w_on_frame ? S_SQ : S_IDLE;
            S_SQ:    if (r_cnt == 6'd2) n_state = S_SQRT;
            S_SQRT:  if (r_cnt == 6'd0) n_state = S_SPD;
            S_SPD: begin
                priority if (w_spd < r_floor) begin
                    n_state = S_IDLE;
                end else if (w_diff >= r_span) begin
                    n_state = S_COLOR;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:   if (r_cnt == 6'd0) n_state = S_PINIT;
            S_PINIT: n_state = S_PSQRT;
            S_PSQRT: if (r_cnt == 6'd0) n_state = S_COLOR;
            S_COLOR: n_state = S_E1;
            S_E1:    n_state = S_E2;
            S_E2:    n_state = S_E3;
            S_E3:    n_state = (r_oi == OIW'(2 * NOFF - 1)) ? S_W1 : S_E1;
            S_W1:    n_state = S_W2;
            S_W2:    n_state = S_W3;
            S_W3:    n_state = S_W4;
            S_W4:    n_state = (r_k >= K_LIMIT) ? S_MUL : S_WDIV;
            S_WDIV:  if (r_cnt == 6'd0) n_state = S_WGET;
            S_WGET:  n_state = S_MUL;
            S_MUL:   n_state = S_WR;
            S_WR: begin
                if (r_ii == DW'(NOFF - 1) && r_jj == DW'(NOFF - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_W1;
                end
            end
            S_RD1:   n_state = S_RD2;
            S_RD2:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ram control and handshake outputs
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = w_pix_addr;
        w_wdata = w_new;
        w_raddr = w_pix_addr;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_MUL:   w_re = 1'b1;
            S_WR:    w_we = 1'b1;
            S_RD1: begin
                w_re    = 1'b1;
                w_raddr = AW'(r_pix_idx);
            end
            default: ;
        endcase
    end

    assign i_body.ready  = (r_state == S_IDLE);
    assign o_pixel.valid = r_out_valid;
    assign o_pixel.red   = r_red;
    assign o_pixel.green = r_green;
    assign o_pixel.blue  = r_blue;
    assign pready        = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_SPEED_FLOOR: prdata = r_floor;
            REG_SPEED_SPAN:  prdata = r_span;
            REG_SHARPNESS:   prdata = {16'd0, r_sharp};
            default:         prdata = {16'd0, r_bright};
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_floor     <= SPEED_FLOOR_RST;
            r_span      <= SPEED_SPAN_RST;
            r_sharp     <= SHARPNESS_RST;
            r_bright    <= BRIGHTNESS_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end else begin
                r_clr <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pixel.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    REG_SPEED_FLOOR: r_floor  <= pwdata;
                    REG_SPEED_SPAN:  r_span   <= pwdata;
                    REG_SHARPNESS:   r_sharp  <= pwdata[15:0];
                    default:         r_bright <= pwdata[15:0];
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_pos_x   <= i_body.pos_x;
                r_pos_y   <= i_body.pos_y;
                r_vel[0]  <= i_body.vel_x;
                r_vel[1]  <= i_body.vel_y;
                r_vel[2]  <= i_body.vel_z;
                r_pix_idx <= i_body.pixel_index;
            end
            S_PROJ: begin
                r_cx <= CXW'(w_px1) * CX_W;
                r_cy <= CXW'(w_py1) * CX_H;
            end
            S_EDGE: begin
                r_sq_n   <= '0;
                r_sq_r   <= '0;
                r_sq_bit <= 64'd1 << 62;
                r_cnt    <= '0;
            end
            S_SQ: begin
                r_sq_n <= r_sq_n + w_sq;
                r_cnt  <= (r_cnt == 6'd2) ? 6'd31 : r_cnt + 6'd1;
            end
            S_SQRT, S_PSQRT: begin
                if (r_sq_n >= w_sq_t) begin
                    r_sq_n <= r_sq_n - w_sq_t;
                    r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_cnt    <= r_cnt - 6'd1;
            end
            S_SPD: begin
                // a zero span also lands on the full ramp
                r_full   <= w_diff >= r_span;
                r_dv_rem <= 65'(w_diff);
                r_dv_q   <= '0;
                r_dv_den <= 64'(r_span);
                r_cnt    <= 6'd31;
            end
            S_DIV, S_WDIV: begin
                r_dv_rem <= w_dv_ge ? w_dv_sh - 65'(r_dv_den) : w_dv_sh;
                r_dv_q   <= {r_dv_q[62:0], w_dv_ge};
                r_cnt    <= r_cnt - 6'd1;
            end
            S_PINIT: begin
                r_sq_n   <= 64'(r_dv_q[31:0]);
                r_sq_r   <= '0;
                r_sq_bit <= 64'd1 << 62;
                r_cnt    <= 6'd31;
            end
            S_COLOR: begin
                r_col[0] <= f_clamp((w_p - C_THIRD) <<< 2);
                r_col[1] <= f_clamp((w_cg_a < w_cg_b) ? w_cg_a : w_cg_b);
                r_col[2] <= f_clamp((C_HALF - w_p) <<< 2);
                r_oi     <= '0;
            end
            S_E1: r_ea <= 24'((43'(w_mag) * 43'(r_sharp)) >> 19);
            S_E2: r_et <= 32'((48'(r_ea) * 48'(r_ea)) >> 16);
            S_E3: begin
                if (w_is_y) begin
                    r_yb[w_rel] <= (w_ex > 33'(EXP_CAP)) ? EXP_CAP : w_ex[XAW-1:0];
                end else begin
                    r_xa[w_rel] <= (w_ex > 33'(EXP_CAP)) ? EXP_CAP : w_ex[XAW-1:0];
                end
                r_oi <= r_oi + OIW'(1);
                r_ii <= '0;
                r_jj <= '0;
            end
            S_W1: begin
                r_hi <= (w_xa > w_yb) ? w_xa : w_yb;
                r_dd <= (w_xa > w_yb) ? w_xa - w_yb : w_yb - w_xa;
            end
            S_W2: r_l2 <= 24'(r_hi) + 24'(w_soft);
            S_W3: begin
                r_k <= w_lq[23:16];
                r_m <= w_p0 + 18'((30'(w_p1 - w_p0) * 30'(w_lq[11:0])) >> 12);
            end
            S_W4: begin
                // far-off dot gives zero weight
                r_w      <= '0;
                r_dv_rem <= '0;
                r_dv_q   <= {r_bright, 48'd0};
                r_dv_den <= (64'(r_m) << r_k[5:0]) + 64'(ONE_Q16);
                r_cnt    <= 6'd35;
            end
            S_WGET: r_w <= r_dv_q[20:0];
            S_MUL: begin
                for (int c = 0; c < 3; c++) begin
                    r_add[c] <= 22'((38'(r_col[c]) * 38'(r_w)) >> 16);
                end
            end
            S_WR: begin
                if (r_jj == DW'(NOFF - 1)) begin
                    r_jj <= '0;
                    r_ii <= r_ii + DW'(1);
                end else begin
                    r_jj <= r_jj + DW'(1);
                end
            end
            S_RD1: r_rd_ok <= 32'(r_pix_idx) < 32'(NPIX);
            S_RD2: begin
                if (w_out_load) begin
                    r_red   <= w_byte[0];
                    r_green <= w_byte[1];
                    r_blue  <= w_byte[2];
                end
            end
            default: ;
        endcase
    end
endmodule

[tb/sv/psa_tb_if.sv]
// no extra channel definitions are needed beyond the block's own interfaces
`timescale 1ns / 100ps

[tb/sv/particle_splat_accumulator_tb.sv]
// testbench of the particle splat accumulator: random bodies and reads against a pixel predictor
`timescale 1ns / 100ps
module particle_splat_accumulator_tb;
    import psa_pkg::*;

    localparam int NPIX = PSA_IMG_WIDTH * PSA_IMG_HEIGHT;

    typedef struct {
        logic [1:0]         action;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [15:0]        pix;
    } t_body_item;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pixel_bytes;

    // pixel predictor and queue of awaited pixel reads
    class t_splat_scoreboard;
        int unsigned   acc_r[NPIX];
        int unsigned   acc_g[NPIX];
        int unsigned   acc_b[NPIX];
        longint unsigned floor_v, span_v, sharp_v, bright_v;
        t_pixel_bytes  awaited[$];
        int            errors;
        int            n_bodies, n_drawn, n_reads, n_clears;

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        function void clear_image();
            foreach (acc_r[k]) begin
                acc_r[k] = 0;
                acc_g[k] = 0;
                acc_b[k] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_SPEED_FLOOR: floor_v  = val;
                REG_SPEED_SPAN:  span_v   = val;
                REG_SHARPNESS:   sharp_v  = val[15:0];
                REG_BRIGHTNESS:  bright_v = val[15:0];
            endcase
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned r, bit_v;
            r = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > n) bit_v >>= 2;
            while (bit_v != 0) begin
                if (n >= r + bit_v) begin
                    n -= r + bit_v;
                    r = (r >> 1) + bit_v;
                end else begin
                    r >>= 1;
                end
                bit_v >>= 2;
            end
            return r;
        endfunction

        // base-2 exponent of e^(a^2) for one sub-pixel offset
        function longint unsigned falloff_arg(longint d);
            longint unsigned mag, a, t, x;
            mag = (d < 0) ? -d : d;
            a = (mag * sharp_v) >> 19;
            if (a > (64'd1 << 24)) a = 64'd1 << 24;
            t = (a * a) >> 16;
            x = (t * 64'd94548) >> 16;
            return (x > (64'd64 << 16)) ? (64'd64 << 16) : x;
        endfunction

        function longint unsigned soft_log2(longint unsigned d);
            longint unsigned lo, hi;
            if (d >= (64'd8 << 16)) return 0;
            lo = soft_tab(5'(d >> 15));
            hi = soft_tab(5'((d >> 15) + 1));
            return lo - (((lo - hi) * (d & 64'h7FFF)) >> 15);
        endfunction

        function longint unsigned dot_weight(longint unsigned xa, longint unsigned xb);
            longint unsigned hi, lo, l2, lw, k, f, m, den, t0, t1;
            hi = (xa > xb) ? xa : xb;
            lo = (xa > xb) ? xb : xa;
            l2 = hi + soft_log2(hi - lo);
            lw = (3 * l2) >> 2;
            k = lw >> 16;
            if (k >= 40) return 0;
            f = lw & 64'hFFFF;
            t0 = pow2_tab(5'(f >> 12));
            t1 = pow2_tab(5'((f >> 12) + 1));
            m = t0 + (((t1 - t0) * (f & 64'hFFF)) >> 12);
            den = (m << k) + 64'd65536;
            return (bright_v << 20) / den;
        endfunction

        function longint clamp_unit(longint v);
            if (v < 0) return 0;
            if (v > 65536) return 65536;
            return v;
        endfunction

        function int unsigned sat_add(int unsigned acc, longint unsigned add);
            longint unsigned s;
            s = acc + add;
            return (s > 64'hFFFFF) ? 32'hFFFFF : int'(s);
        endfunction

        function void splat(t_body_item it);
            longint cx, cy, xp, yp, fx, fy, p, cr, cg, cb, idx;
            longint unsigned ax, ay, az, spd, diff, w, xa, yb;
            cx = 256 * (longint'(it.px) + (64'sd1 <<< 22));
            cy = 256 * (longint'(it.py) + (64'sd1 <<< 22));
            xp = cx >>> 23;
            yp = cy >>> 23;
            fx = cx - xp * (64'sd1 <<< 23);
            fy = cy - yp * (64'sd1 <<< 23);
            if (!(xp > PSA_DOT_SPAN && xp < PSA_IMG_WIDTH - PSA_DOT_SPAN &&
                  yp > PSA_DOT_SPAN && yp < PSA_IMG_HEIGHT - PSA_DOT_SPAN)) return;
            ax = (it.vx < 0) ? -longint'(it.vx) : longint'(it.vx);
            ay = (it.vy < 0) ? -longint'(it.vy) : longint'(it.vy);
            az = (it.vz < 0) ? -longint'(it.vz) : longint'(it.vz);
            spd = int_root(ax * ax + ay * ay + az * az);
            if (spd < floor_v) return;
            diff = spd - floor_v;
            if (diff >= span_v) p = 65536;
            else p = int_root((diff << 32) / span_v);
            cr = clamp_unit(4 * (p - 21823));
            cg = clamp_unit((4 * p < 4 * (65536 - p)) ? 4 * p : 4 * (65536 - p));
            cb = clamp_unit(4 * (32768 - p));
            n_drawn++;
            for (int i = -PSA_DOT_SPAN / 2; i < PSA_DOT_SPAN / 2; i++) begin
                xa = falloff_arg(longint'(i) * (64'sd1 <<< 23) - fx);
                for (int j = -PSA_DOT_SPAN / 2; j < PSA_DOT_SPAN / 2; j++) begin
                    yb = falloff_arg(longint'(j) * (64'sd1 <<< 23) - fy);
                    w = dot_weight(xa, yb);
                    idx = (xp + i) + 256 * (yp + j);
                    if (idx >= 0 && idx < NPIX) begin
                        acc_r[idx] = sat_add(acc_r[idx], (longint'(cr) * w) >> 16);
                        acc_g[idx] = sat_add(acc_g[idx], (longint'(cg) * w) >> 16);
                        acc_b[idx] = sat_add(acc_b[idx], (longint'(cb) * w) >> 16);
                    end
                end
            end
        endfunction

        function logic [7:0] to_byte(int unsigned a);
            longint unsigned v;
            v = (a > 65536) ? 65536 : a;
            return 8'((255 * v) >> 16);
        endfunction

        // accepted input item: update the image and queue any read result
        function void note_item(t_body_item it);
            t_pixel_bytes e;
            case (it.action)
                ACT_CLEAR: begin
                    n_clears++;
                    clear_image();
                end
                ACT_BODY: begin
                    n_bodies++;
                    splat(it);
                end
                ACT_READ: begin
                    n_reads++;
                    e = '{8'd0, 8'd0, 8'd0};
                    if (it.pix < NPIX) begin
                        e.r = to_byte(acc_r[it.pix]);
                        e.g = to_byte(acc_g[it.pix]);
                        e.b = to_byte(acc_b[it.pix]);
                    end
                    awaited.push_back(e);
                end
                default: ;
            endcase
        endfunction

        task check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            t_pixel_bytes e;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected pixel %0d/%0d/%0d", r, g, b));
                return;
            end
            e = awaited.pop_front();
            if (r !== e.r) report($sformatf("red %0d, want %0d", r, e.r));
            if (g !== e.g) report($sformatf("green %0d, want %0d", g, e.g));
            if (b !== e.b) report($sformatf("blue %0d, want %0d", b, e.b));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    psa_in_if  body_if ();
    psa_out_if pix_if ();

    particle_splat_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_body  (body_if),
        .o_pixel (pix_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_splat_scoreboard sb;
    int  last_xp = 128, last_yp = 128;
    bit  tx_calm, rx_calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: far beyond the slowest correct run including clear sweeps
    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    // input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        if (i_rst_n && body_if.valid && body_if.ready)
            sb.note_item('{body_if.action, body_if.pos_x, body_if.pos_y,
                           body_if.vel_x, body_if.vel_y, body_if.vel_z,
                           body_if.pixel_index});
        if (i_rst_n && pix_if.valid && pix_if.ready)
            sb.check_pixel(pix_if.red, pix_if.green, pix_if.blue);
    end

    // result side: random stall before each transfer, with calm stretches
    initial begin
        int gap;
        pix_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 40) == 0) rx_calm = ~rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 13);
            repeat (gap) begin
                pix_if.ready = 1'b0;
                @(negedge i_clk);
            end
            pix_if.ready = 1'b1;
            do @(posedge i_clk); while (!pix_if.valid);
        end
    end

    // one input transfer, preceded by a random gap
    task send_item(t_body_item it);
        int gap;
        if ($urandom_range(0, 40) == 0) tx_calm = ~tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        repeat (gap) begin
            body_if.valid = 1'b0;
            @(negedge i_clk);
        end
        body_if.action      = it.action;
        body_if.pos_x       = it.px;
        body_if.pos_y       = it.py;
        body_if.vel_x       = it.vx;
        body_if.vel_y       = it.vy;
        body_if.vel_z       = it.vz;
        body_if.pixel_index = it.pix;
        body_if.valid       = 1'b1;
        do @(posedge i_clk); while (!body_if.ready);
    endtask

    task apb_write(logic [1:0] idx, logic [31:0] val);
        logic [31:0] back;
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        sb.set_reg(idx, val);
        // read back the register
        @(negedge i_clk);
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        back = prdata;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
        if (idx == REG_SHARPNESS || idx == REG_BRIGHTNESS) val = {16'd0, val[15:0]};
        if (back !== val) sb.report($sformatf("register %0d reads %0h, want %0h", idx, back, val));
    endtask

    // idle between phases: results drained, last body finished, block ready
    task wait_idle();
        @(negedge i_clk);
        body_if.valid = 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        while (!body_if.ready) @(posedge i_clk);
    endtask

    function t_body_item body_at(int xp, int yp, longint vmax);
        t_body_item it;
        it.action = ACT_BODY;
        it.px = 24'((xp - 128) * 32768 + $urandom_range(0, 32767));
        it.py = 24'((yp - 128) * 32768 + $urandom_range(0, 32767));
        it.vx = 32'(longint'($urandom_range(0, 32'(vmax))) * ($urandom_range(0, 1) ? 1 : -1));
        it.vy = 32'(longint'($urandom_range(0, 32'(vmax))) * ($urandom_range(0, 1) ? 1 : -1));
        it.vz = 32'(longint'($urandom_range(0, 32'(vmax))) * ($urandom_range(0, 1) ? 1 : -1));
        it.pix = 16'($urandom);
        return it;
    endfunction

    function t_body_item read_at(int xp, int yp);
        t_body_item it;
        it = body_at(128, 128, 10);
        it.action = ACT_READ;
        it.pix = 16'((xp + $urandom_range(0, 5) - 3) + 256 * (yp + $urandom_range(0, 5) - 3));
        return it;
    endfunction

    // mostly well-formed bodies followed by reads round them, some noise
    task random_items(int n);
        t_body_item it;
        int sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                last_xp = $urandom_range(5, 251);
                last_yp = $urandom_range(5, 251);
                it = body_at(last_xp, last_yp, $urandom_range(0, 3) == 0 ? 64'hFFFFFFFF : 60000);
            end else if (sel < 85) begin
                it = read_at(last_xp, last_yp);
            end else if (sel < 92) begin
                it = body_at(128, 128, 10);
                it.action = ACT_READ;
            end else if (sel < 98) begin
                it = body_at(128, 128, 10);
                it.px = 24'($urandom); it.py = 24'($urandom);
                it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
            end else begin
                it = body_at(128, 128, 10);
                it.action = 2'd3;
            end
            send_item(it);
        end
    endtask

    task directed_items();
        t_body_item it;
        it = body_at(128, 128, 40000);                 // centre body then reads
        send_item(it);
        for (int k = 0; k < 4; k++) send_item(read_at(128, 128));
        it = body_at(5, 5, 0);                          // zero speed, corner inside frame
        send_item(it);
        it = body_at(251, 251, 64'hFFFFFFFF);
        it.vx = 32'h80000000; it.vy = 32'h80000000; it.vz = 32'h7FFFFFFF;
        send_item(it);                                  // extreme velocities
        it.px = 24'h800000; it.py = 24'h7FFFFF;         // off the frame edge
        send_item(it);
        it = body_at(4, 128, 1000);                     // just outside the margin
        send_item(it);
        it = body_at(128, 252, 1000);
        send_item(it);
        it.action = 2'd3;                               // unused action
        send_item(it);
        it = read_at(128, 128); it.pix = 16'hFFFF;
        send_item(it);
        it.pix = 16'h0000;
        send_item(it);
        send_item(read_at(251, 251));
        send_item(read_at(5, 5));
    endtask

    task clear_image_item();
        t_body_item it;
        it = body_at(128, 128, 10);
        it.action = ACT_CLEAR;
        send_item(it);
    endtask

    initial begin
        sb = new();
        sb.clear_image();
        sb.floor_v = SPEED_FLOOR_RST; sb.span_v = SPEED_SPAN_RST;
        sb.sharp_v = SHARPNESS_RST; sb.bright_v = BRIGHTNESS_RST;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        body_if.valid = 1'b0; body_if.action = ACT_CLEAR;
        body_if.pos_x = '0; body_if.pos_y = '0;
        body_if.vel_x = '0; body_if.vel_y = '0; body_if.vel_z = '0;
        body_if.pixel_index = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings, directed part, random part
        directed_items();
        random_items(200);
        wait_idle();

        // full ramp at once, no falloff, peak brightness
        apb_write(REG_SPEED_FLOOR, 32'd0);
        apb_write(REG_SPEED_SPAN, 32'd1);
        apb_write(REG_SHARPNESS, 32'd0);
        apb_write(REG_BRIGHTNESS, 32'hFFFF);
        random_items(180);
        wait_idle();

        // zero span, sharpest falloff: far-off weights vanish
        apb_write(REG_SPEED_SPAN, 32'd0);
        apb_write(REG_SHARPNESS, 32'hFFFF);
        clear_image_item();
        random_items(150);
        wait_idle();

        // every body too slow, zero brightness
        apb_write(REG_SPEED_FLOOR, 32'hFFFFFFFF);
        apb_write(REG_SPEED_SPAN, 32'hFFFFFFFF);
        apb_write(REG_BRIGHTNESS, 32'd0);
        random_items(120);
        wait_idle();

        // mid settings with a floor inside the velocity spread
        apb_write(REG_SPEED_FLOOR, 32'd30000);
        apb_write(REG_SPEED_SPAN, 32'd50000);
        apb_write(REG_SHARPNESS, 32'd8192);
        apb_write(REG_BRIGHTNESS, 32'd12000);
        clear_image_item();
        random_items(250);
        wait_idle();

        // random settings
        apb_write(REG_SPEED_FLOOR, $urandom_range(0, 20000));
        apb_write(REG_SPEED_SPAN, $urandom_range(1, 200000));
        apb_write(REG_SHARPNESS, $urandom_range(0, 65535));
        apb_write(REG_BRIGHTNESS, $urandom_range(0, 65535));
        random_items(230);
        wait_idle();

        $display("run covered %0d bodies (%0d drawn), %0d pixel reads, %0d clears",
                 sb.n_bodies, sb.n_drawn, sb.n_reads, sb.n_clears);
        $display("over six register settings, with %0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
